// ----- hdl/ps2km_pkg.sv -----
package ps2km_pkg;

  // Request kinds carried in the input tuser
  typedef enum logic [2:0] {
    FUNC_BIT         = 3'd0,
    FUNC_LOAD_KEYMAP = 3'd1,
    FUNC_LOAD_EDITOR = 3'd2,
    FUNC_READ_ROW    = 3'd3,
    FUNC_ACK         = 3'd4
  } func_e;

  // Scancodes with fixed meaning
  localparam logic [7:0] SC_BREAK  = 8'hF0;
  localparam logic [7:0] SC_F1     = 8'h05;
  localparam logic [7:0] SC_F2     = 8'h06;
  localparam logic [7:0] SC_SCROLL = 8'h7E;
  localparam logic [7:0] SC_LCTRL  = 8'h14;
  localparam logic [7:0] SC_LSHIFT = 8'h12;
  localparam logic [7:0] SC_RSHIFT = 8'h59;
  localparam logic [7:0] SC_LALT   = 8'h11;

  // Action request codes
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_F1   = 2'd1;
  localparam logic [1:0] ACT_F2   = 2'd2;

  // Matrix layout of the modifier keys
  localparam int         CTRL_ROW   = 0;
  localparam int         ALT_ROW    = 5;
  localparam logic [7:0] CTRL_BIT   = 8'h08;
  localparam logic [7:0] SHIFT_BIT  = 8'h10;
  localparam logic [7:0] ALT_BIT    = 8'h40;

  // PS/2 frame: start bit low, stop bit high, parity ignored
  localparam logic [3:0]  FRAME_BITS = 4'd11;
  localparam logic [10:0] FRAME_MASK = 11'h401;
  localparam logic [10:0] FRAME_OK   = 11'h400;

  // Acknowledge mask bits
  localparam int ACK_NMI    = 0;
  localparam int ACK_EDCHAR = 1;
  localparam int ACK_EDIT   = 2;
  localparam int ACK_ACTION = 3;

  // Input word, last field in the lowest bits
  typedef struct packed {
    logic [5:0] pad;
    logic [3:0] ack_mask;
    logic [7:0] char_value;
    logic [7:0] code;
    logic [5:0] entry_index;
    logic [2:0] col;
    logic [3:0] row;
    logic       data_bit;
  } in_word_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [1:0] pad;
    logic [7:0] received_byte;
    logic       byte_valid;
    logic       editor_char_new;
    logic [7:0] editor_char;
    logic       nmi_request;
    logic [1:0] action_request;
    logic       edit_active;
    logic [7:0] row_bits;
  } out_word_t;

  // Frame receiver report
  typedef struct packed {
    logic       done;
    logic       ok;
    logic [7:0] data;
  } rx_byte_t;

  // Table search report
  typedef struct packed {
    logic hit;
    logic done;
  } srch_status_t;

endpackage

// ----- hdl/ps2_keyboard_to_key_matrix_top.sv -----
// PS/2 keyboard receiver driving an emulated key matrix.
//
// Input channel (s_axis): one word per request. tuser selects the request:
// a PS/2 data bit sampled at a falling keyboard clock edge, a keymap load,
// an editor table load, a matrix row read or a flag acknowledge.
// Output channel (m_axis): exactly one result word per request, in order,
// carrying the row read, the flags after the request and any byte that the
// request completed.
//
// A make code that needs a keymap lookup sweeps the keymap RAM, and a release
// in edit mode sweeps the editor RAM, one entry a cycle. One request is in
// work at a time; the output register holds one finished word meanwhile.
//
// Reset clears the frame receiver, the matrix, all flags and the valid bits
// of both tables, so every table entry reads as zero until loaded. When the
// receiver stalls, the finished word waits in the output register and the
// block stops taking requests once its next result is ready as well.
module ps2_keyboard_to_key_matrix_top #(
  parameter int MATRIX_ROWS    = 9,
  parameter int EDITOR_ENTRIES = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_bit, row[3:0], col[2:0], entry_index[5:0], code[7:0],
  // char_value[7:0], ack_mask[3:0], zero pad[5:0]
  input  logic [39:0] s_axis_tdata,
  // func[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // row_bits[7:0], edit_active, action_request[1:0], nmi_request,
  // editor_char[7:0], editor_char_new, byte_valid, received_byte[7:0],
  // zero pad[1:0]
  output logic [31:0] m_axis_tdata
);

  localparam int KM_DEPTH = MATRIX_ROWS * 8;
  localparam int KM_AW    = $clog2(KM_DEPTH);
  localparam int ED_AW    = (EDITOR_ENTRIES > 1) ? $clog2(EDITOR_ENTRIES) : 1;
  localparam int ROW_W    = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
  localparam bit HAS_ALT  = (MATRIX_ROWS > ps2km_pkg::ALT_ROW);
  localparam int ALT_IDX  = HAS_ALT ? ps2km_pkg::ALT_ROW : 0;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  ps2km_pkg::in_word_t     in_w;
  ps2km_pkg::out_word_t    out_w;
  ps2km_pkg::rx_byte_t     rx;
  ps2km_pkg::srch_status_t km_st, ed_st;

  logic [1:0]       state_q;
  logic [7:0]       km_q [MATRIX_ROWS];
  logic             nbp_q, ebp_q;
  logic             edit_q, nmi_q, ekf_q;
  logic [1:0]       act_q;
  logic [7:0]       ekv_q;
  logic [7:0]       rowv_q, byte_q;
  logic             bvalid_q;
  logic             out_valid_q;
  logic [31:0]      out_data_q;

  logic             accept, bit_en, byte_ok;
  logic             is_special, is_mod;
  logic             km_start, ed_start;
  logic             km_wr, ed_wr;
  logic [7:0]       rowv;
  logic [KM_AW-1:0] km_hit_idx;
  logic [7:0]       km_hit_data;
  logic [ED_AW-1:0] ed_hit_idx;
  logic [15:0]      ed_hit_data;
  logic [ROW_W-1:0] hit_row;
  logic [2:0]       hit_col;
  logic             out_free;

  assign in_w          = ps2km_pkg::in_word_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign bit_en        = accept && (s_axis_tuser == ps2km_pkg::FUNC_BIT);
  assign km_wr         = accept && (s_axis_tuser == ps2km_pkg::FUNC_LOAD_KEYMAP)
                         && (in_w.row < MATRIX_ROWS);
  assign ed_wr         = accept && (s_axis_tuser == ps2km_pkg::FUNC_LOAD_EDITOR)
                         && (in_w.entry_index < EDITOR_ENTRIES);

  ps2km_rx u_rx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bit_en_i   (bit_en),
    .data_bit_i (in_w.data_bit),
    .rx_o       (rx)
  );

  // Classify a completed byte
  always_comb begin
    byte_ok    = rx.done && rx.ok;
    is_special = rx.data inside {ps2km_pkg::SC_BREAK, ps2km_pkg::SC_F1,
                                 ps2km_pkg::SC_F2, ps2km_pkg::SC_SCROLL};
    is_mod     = rx.data inside {ps2km_pkg::SC_LCTRL, ps2km_pkg::SC_LSHIFT,
                                 ps2km_pkg::SC_RSHIFT, ps2km_pkg::SC_LALT};
    km_start   = byte_ok && !edit_q && !is_special && !nbp_q && !is_mod;
    ed_start   = byte_ok && edit_q && (rx.data != ps2km_pkg::SC_BREAK) && ebp_q;
  end

  ps2km_search #(
    .WIDTH (8),
    .DEPTH (KM_DEPTH),
    .AW    (KM_AW)
  ) u_km_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (km_wr),
    .wr_addr_i  (KM_AW'({in_w.row, in_w.col})),
    .wr_data_i  (in_w.code),
    .start_i    (km_start),
    .key_i      (rx.data),
    .status_o   (km_st),
    .hit_idx_o  (km_hit_idx),
    .hit_data_o (km_hit_data)
  );

  ps2km_search #(
    .WIDTH (16),
    .DEPTH (EDITOR_ENTRIES),
    .AW    (ED_AW)
  ) u_ed_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (ed_wr),
    .wr_addr_i  (ED_AW'(in_w.entry_index)),
    .wr_data_i  ({in_w.char_value, in_w.code}),
    .start_i    (ed_start),
    .key_i      (rx.data),
    .status_o   (ed_st),
    .hit_idx_o  (ed_hit_idx),
    .hit_data_o (ed_hit_data)
  );

  // Keymap hit position: row and bit within the row
  assign hit_row = ROW_W'(km_hit_idx >> 3);
  assign hit_col = km_hit_idx[2:0];

  // Row read, out-of-range rows read as zero
  assign rowv = (in_w.row < MATRIX_ROWS) ? km_q[in_w.row[ROW_W-1:0]] : '0;

  // Request sequencer, matrix and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int r = 0; r < MATRIX_ROWS; r++) begin
        km_q[r] <= '0;
      end
      nbp_q  <= 1'b0;
      ebp_q  <= 1'b0;
      edit_q <= 1'b0;
      act_q  <= ps2km_pkg::ACT_NONE;
      nmi_q  <= 1'b0;
      ekv_q  <= '0;
      ekf_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= (km_start || ed_start) ? ST_SCAN : ST_FIN;
            case (s_axis_tuser)
              ps2km_pkg::FUNC_BIT: begin
                if (byte_ok && !edit_q) begin
                  // Normal mode: update the matrix and the flags
                  case (rx.data)
                    ps2km_pkg::SC_BREAK: nbp_q <= 1'b1;
                    ps2km_pkg::SC_F1: begin
                      edit_q <= 1'b1;
                      act_q  <= ps2km_pkg::ACT_F1;
                    end
                    ps2km_pkg::SC_F2: begin
                      edit_q <= 1'b1;
                      act_q  <= ps2km_pkg::ACT_F2;
                    end
                    ps2km_pkg::SC_SCROLL: nmi_q <= 1'b1;
                    default: begin
                      if (nbp_q) begin
                        nbp_q <= 1'b0;
                        if (rx.data inside {ps2km_pkg::SC_LCTRL, ps2km_pkg::SC_LSHIFT,
                                            ps2km_pkg::SC_RSHIFT}) begin
                          km_q[ps2km_pkg::CTRL_ROW] <= '0;
                        end else if (rx.data == ps2km_pkg::SC_LALT) begin
                          if (HAS_ALT) begin
                            km_q[ALT_IDX] <= '0;
                          end
                        end else begin
                          // Release of any other key: clear rows from 1 up, keeping the held ALT
                          for (int r = 1; r < MATRIX_ROWS; r++) begin
                            km_q[r] <= '0;
                          end
                          if (HAS_ALT) begin
                            km_q[ALT_IDX] <= km_q[ALT_IDX] & ps2km_pkg::ALT_BIT;
                          end
                        end
                      end else if (rx.data == ps2km_pkg::SC_LCTRL) begin
                        km_q[ps2km_pkg::CTRL_ROW] <= ps2km_pkg::CTRL_BIT;
                      end else if (rx.data inside {ps2km_pkg::SC_LSHIFT,
                                                   ps2km_pkg::SC_RSHIFT}) begin
                        km_q[ps2km_pkg::CTRL_ROW] <= ps2km_pkg::SHIFT_BIT;
                      end else if (rx.data == ps2km_pkg::SC_LALT) begin
                        if (HAS_ALT) begin
                          km_q[ALT_IDX] <= ps2km_pkg::ALT_BIT;
                        end
                      end
                    end
                  endcase
                end else if (byte_ok) begin
                  // Edit mode: track the release prefix
                  ebp_q <= (rx.data == ps2km_pkg::SC_BREAK);
                end
              end
              ps2km_pkg::FUNC_ACK: begin
                if (in_w.ack_mask[ps2km_pkg::ACK_NMI]) begin
                  nmi_q <= 1'b0;
                end
                if (in_w.ack_mask[ps2km_pkg::ACK_EDCHAR]) begin
                  ekf_q <= 1'b0;
                end
                if (in_w.ack_mask[ps2km_pkg::ACK_EDIT]) begin
                  edit_q <= 1'b0;
                end
                if (in_w.ack_mask[ps2km_pkg::ACK_ACTION]) begin
                  act_q <= ps2km_pkg::ACT_NONE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Apply hits in sweep order so the last match wins
          if (km_st.hit) begin
            km_q[hit_row] <= 8'b1 << hit_col;
          end
          if (ed_st.hit) begin
            ekv_q <= ed_hit_data[15:8];
            ekf_q <= 1'b1;
          end
          if (km_st.done || ed_st.done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Capture per-request result fields at acceptance
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rowv_q   <= (s_axis_tuser == ps2km_pkg::FUNC_READ_ROW) ? rowv : '0;
      bvalid_q <= byte_ok;
      byte_q   <= byte_ok ? rx.data : '0;
    end
  end

  // Assemble the result word from the state after the request
  always_comb begin
    out_w                 = '0;
    out_w.row_bits        = rowv_q;
    out_w.edit_active     = edit_q;
    out_w.action_request  = act_q;
    out_w.nmi_request     = nmi_q;
    out_w.editor_char     = ekv_q;
    out_w.editor_char_new = ekf_q;
    out_w.byte_valid      = bvalid_q;
    out_w.received_byte   = byte_q;
  end

  assign out_free = !out_valid_q || m_axis_tready;

  // Output register: drop the word once taken, load the next when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && out_free) begin
      out_data_q <= out_w;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- hdl/ps2km_ram.sv -----
module ps2km_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 72,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- hdl/ps2km_rx.sv -----
module ps2km_rx (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                bit_en_i,
  input  logic                data_bit_i,
  output ps2km_pkg::rx_byte_t rx_o
);

  logic [10:0] shift_q, shift_d;
  logic [3:0]  cnt_q, cnt_inc;
  logic        frame_end;

  // Merge the new bit at its frame position
  always_comb begin
    shift_d        = shift_q;
    shift_d[cnt_q] = shift_q[cnt_q] | data_bit_i;
    cnt_inc        = cnt_q + 4'd1;
    frame_end      = (cnt_inc == ps2km_pkg::FRAME_BITS);
  end

  // Report a finished frame in the cycle of its last bit
  assign rx_o.done = bit_en_i && frame_end;
  assign rx_o.ok   = ((shift_d & ps2km_pkg::FRAME_MASK) == ps2km_pkg::FRAME_OK);
  assign rx_o.data = shift_d[8:1];

  // Advance the frame, restart after the stop bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      cnt_q   <= '0;
    end else if (bit_en_i) begin
      if (frame_end) begin
        shift_q <= '0;
        cnt_q   <= '0;
      end else begin
        shift_q <= shift_d;
        cnt_q   <= cnt_inc;
      end
    end
  end

endmodule

// ----- hdl/ps2km_search.sv -----
module ps2km_search #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 72,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [AW-1:0]           wr_addr_i,
  input  logic [WIDTH-1:0]        wr_data_i,
  input  logic                    start_i,
  input  logic [7:0]              key_i,
  output ps2km_pkg::srch_status_t status_o,
  output logic [AW-1:0]           hit_idx_o,
  output logic [WIDTH-1:0]        hit_data_o
);

  logic [DEPTH-1:0] vld_q;
  logic             issue_q;
  logic [AW-1:0]    cnt_q;
  logic [7:0]       key_q;
  logic             chk_q;
  logic             chk_vld_q;
  logic [AW-1:0]    chk_idx_q;
  logic [WIDTH-1:0] rd_data;
  logic [WIDTH-1:0] entry;

  ps2km_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en_i),
    .wr_addr_i (wr_addr_i),
    .wr_data_i (wr_data_i),
    .rd_en_i   (issue_q),
    .rd_addr_i (cnt_q),
    .rd_data_o (rd_data)
  );

  // Mark written entries; unwritten ones read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Sweep addresses in ascending order, one read a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      chk_q   <= 1'b0;
    end else begin
      chk_q <= issue_q;
      if (start_i) begin
        issue_q <= 1'b1;
      end else if (issue_q && (cnt_q == AW'(DEPTH - 1))) begin
        issue_q <= 1'b0;
      end
    end
  end

  // Address counter, key and compare-stage tags
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q <= '0;
      key_q <= key_i;
    end else if (issue_q && (cnt_q != AW'(DEPTH - 1))) begin
      cnt_q <= cnt_q + AW'(1);
    end
    chk_idx_q <= cnt_q;
    chk_vld_q <= vld_q[cnt_q];
  end

  // Compare the returned entry against the key
  assign entry           = chk_vld_q ? rd_data : '0;
  assign status_o.hit    = chk_q && (entry[7:0] == key_q);
  assign status_o.done   = chk_q && (chk_idx_q == AW'(DEPTH - 1));
  assign hit_idx_o       = chk_idx_q;
  assign hit_data_o      = entry;

endmodule

// ----- hdl/ps2km_checker.sv -----
module ps2km_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  ps2km_pkg::out_word_t out_w;

  assign out_w = ps2km_pkg::out_word_t'(m_axis_tdata);

  // Hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // A byte is reported only with its valid flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_w.byte_valid |-> (out_w.received_byte == 8'h00))
    else $error("received byte without byte valid");

  // Action code is one of none, F1, F2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_w.action_request == ps2km_pkg::ACT_NONE) ||
                      (out_w.action_request == ps2km_pkg::ACT_F1) ||
                      (out_w.action_request == ps2km_pkg::ACT_F2))
    else $error("illegal action request code");

endmodule

bind ps2_keyboard_to_key_matrix_top ps2km_checker u_ps2km_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/tb_top.sv -----
module tb_top;
  import ps2km_pkg::*;

  localparam int MATRIX_ROWS    = 9;
  localparam int EDITOR_ENTRIES = 40;
  localparam int KEYMAP_SIZE    = MATRIX_ROWS * 8;
  localparam int TOTAL_WORDS    = 1575;
  localparam int SETTLE_CYCLES  = KEYMAP_SIZE + 3 + 20;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  // One directed request with an optional hand-written result
  typedef struct packed {
    logic [2:0] f;
    in_word_t   w;
    logic       has_typed;
    out_word_t  typed_word;
  } stim_row_t;

  stim_row_t directed_rows[$];
  out_word_t awaited_words[$];
  int        mismatch_count;
  int        words_sent;
  int        tx_calm;
  int        rx_calm;

  // Predicted keyboard state
  logic [10:0] frame_acc;
  logic [3:0]  frame_count;
  logic        mk_break;
  logic        ed_break;
  logic [7:0]  matrix_rows [MATRIX_ROWS];
  logic [7:0]  keymap [KEYMAP_SIZE];
  logic [15:0] editor_tab [EDITOR_ENTRIES];
  logic        edit_q;
  logic [1:0]  action_q;
  logic        nmi_q;
  logic [7:0]  edchar_q;
  logic        edchar_new_q;

  ps2_keyboard_to_key_matrix_top #(
    .MATRIX_ROWS   (MATRIX_ROWS),
    .EDITOR_ENTRIES(EDITOR_ENTRIES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung block
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_word_t mk_word(logic db, logic [3:0] r, logic [2:0] c,
                                       logic [5:0] idx, logic [7:0] cd,
                                       logic [7:0] cv, logic [3:0] ack);
    in_word_t w;
    w = '0;
    w.data_bit    = db;
    w.row         = r;
    w.col         = c;
    w.entry_index = idx;
    w.code        = cd;
    w.char_value  = cv;
    w.ack_mask    = ack;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    return mk_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                   3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)));
  endfunction

  // PS/2 frame, sent from bit 0 up: start, data LSB first, parity, stop
  function automatic logic [10:0] frame_bits(logic [7:0] b, logic start_b, logic stop_b,
                                             logic par);
    return {stop_b, par, b, start_b};
  endfunction

  // Small code set, so that table searches hit and collide
  function automatic logic [7:0] pick_pool_code();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h15;
      2: return 8'h1C;
      3: return 8'h24;
      4: return 8'hFF;
      default: return 8'h4D;
    endcase
  endfunction

  function automatic logic [7:0] pick_scancode();
    case ($urandom_range(0, 15))
      0: return SC_BREAK;
      1: return SC_F1;
      2: return SC_F2;
      3: return SC_SCROLL;
      4: return SC_LCTRL;
      5: return SC_LSHIFT;
      6: return SC_RSHIFT;
      7: return SC_LALT;
      8, 9, 10, 11: return pick_pool_code();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Advance the predicted state by one request and form its result word
  function automatic out_word_t next_result_word(logic [2:0] f, in_word_t w);
    out_word_t  res;
    logic [7:0] b;
    logic [7:0] alt;
    res = '0;
    case (f)
      FUNC_BIT: begin
        if (w.data_bit) frame_acc[frame_count] = 1'b1;
        frame_count = frame_count + 4'd1;
        if (frame_count >= FRAME_BITS) begin
          if ((frame_acc & FRAME_MASK) == FRAME_OK) begin
            b = frame_acc[8:1];
            res.byte_valid    = 1'b1;
            res.received_byte = b;
            if (edit_q) begin
              // Editor lookup on release only, last match wins
              if (b == SC_BREAK) begin
                ed_break = 1'b1;
              end else begin
                if (ed_break) begin
                  for (int i = 0; i < EDITOR_ENTRIES; i++) begin
                    if (editor_tab[i][7:0] == b) begin
                      edchar_q     = editor_tab[i][15:8];
                      edchar_new_q = 1'b1;
                    end
                  end
                end
                ed_break = 1'b0;
              end
            end else if (b == SC_BREAK) begin
              mk_break = 1'b1;
            end else if (b == SC_F1) begin
              edit_q   = 1'b1;
              action_q = ACT_F1;
            end else if (b == SC_F2) begin
              edit_q   = 1'b1;
              action_q = ACT_F2;
            end else if (b == SC_SCROLL) begin
              nmi_q = 1'b1;
            end else if (mk_break) begin
              // Release: modifiers clear their row, others clear rows from 1 up but keep ALT
              mk_break = 1'b0;
              if (b == SC_LCTRL || b == SC_LSHIFT || b == SC_RSHIFT) begin
                matrix_rows[CTRL_ROW] = '0;
              end else if (b == SC_LALT) begin
                matrix_rows[ALT_ROW] = '0;
              end else begin
                alt = matrix_rows[ALT_ROW] & ALT_BIT;
                for (int r = 1; r < MATRIX_ROWS; r++) matrix_rows[r] = '0;
                matrix_rows[ALT_ROW] = alt;
              end
            end else if (b == SC_LCTRL) begin
              matrix_rows[CTRL_ROW] = CTRL_BIT;
            end else if (b == SC_LSHIFT || b == SC_RSHIFT) begin
              matrix_rows[CTRL_ROW] = SHIFT_BIT;
            end else if (b == SC_LALT) begin
              matrix_rows[ALT_ROW] = ALT_BIT;
            end else begin
              for (int r = 0; r < MATRIX_ROWS; r++) begin
                for (int c = 0; c < 8; c++) begin
                  if (keymap[r * 8 + c] == b) matrix_rows[r] = 8'h01 << c;
                end
              end
            end
          end
          frame_acc   = '0;
          frame_count = '0;
        end
      end
      FUNC_LOAD_KEYMAP: begin
        if (w.row < MATRIX_ROWS) keymap[{w.row, w.col}] = w.code;
      end
      FUNC_LOAD_EDITOR: begin
        if (w.entry_index < EDITOR_ENTRIES) editor_tab[w.entry_index] = {w.char_value, w.code};
      end
      FUNC_READ_ROW: begin
        if (w.row < MATRIX_ROWS) res.row_bits = matrix_rows[w.row];
      end
      FUNC_ACK: begin
        if (w.ack_mask[ACK_NMI])    nmi_q        = 1'b0;
        if (w.ack_mask[ACK_EDCHAR]) edchar_new_q = 1'b0;
        if (w.ack_mask[ACK_EDIT])   edit_q       = 1'b0;
        if (w.ack_mask[ACK_ACTION]) action_q     = ACT_NONE;
      end
      default: begin
      end
    endcase
    res.edit_active     = edit_q;
    res.action_request  = action_q;
    res.nmi_request     = nmi_q;
    res.editor_char     = edchar_q;
    res.editor_char_new = edchar_new_q;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] actual_v,
                                 input logic [31:0] wanted_v);
    $display("%0t: %s is %0h, predicted %0h", $time, field, actual_v, wanted_v);
    mismatch_count++;
  endtask

  task automatic check_word(input out_word_t got, input out_word_t want);
    if (got.row_bits !== want.row_bits)
      report_mismatch("row_bits", 32'(got.row_bits), 32'(want.row_bits));
    if (got.edit_active !== want.edit_active)
      report_mismatch("edit_active", 32'(got.edit_active), 32'(want.edit_active));
    if (got.action_request !== want.action_request)
      report_mismatch("action_request", 32'(got.action_request), 32'(want.action_request));
    if (got.nmi_request !== want.nmi_request)
      report_mismatch("nmi_request", 32'(got.nmi_request), 32'(want.nmi_request));
    if (got.editor_char !== want.editor_char)
      report_mismatch("editor_char", 32'(got.editor_char), 32'(want.editor_char));
    if (got.editor_char_new !== want.editor_char_new)
      report_mismatch("editor_char_new", 32'(got.editor_char_new),
                      32'(want.editor_char_new));
    if (got.byte_valid !== want.byte_valid)
      report_mismatch("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
    if (got.received_byte !== want.received_byte)
      report_mismatch("received_byte", 32'(got.received_byte), 32'(want.received_byte));
    if (got.pad !== want.pad)
      report_mismatch("pad", 32'(got.pad), 32'(want.pad));
  endtask

  // Mostly short gaps, a few long ones, and now and then a calm stretch
  task automatic pick_gap(inout int calm, output int gap);
    int roll;
    roll = $urandom_range(0, 199);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if (roll == 0) begin
      calm = $urandom_range(30, 120);
      gap  = 0;
    end else if (roll < 100) begin
      gap = 0;
    end else if (roll < 180) begin
      gap = $urandom_range(1, 3);
    end else if (roll < 196) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 80);
    end
  endtask

  // Offer one word, wait for it to be taken, then predict its result
  task automatic send_word(input logic [2:0] f, input in_word_t w, input logic has_typed,
                           input out_word_t typed_word);
    int        gap;
    out_word_t predicted;
    pick_gap(tx_calm, gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    predicted = next_result_word(f, w);
    awaited_words.push_back(has_typed ? typed_word : predicted);
  endtask

  // Finish any partial frame with zero bits, so it drops on its stop bit, then send the frame
  task automatic send_frame(input logic [7:0] b, input logic start_ok, input logic stop_ok);
    logic [10:0] bits;
    in_word_t    w;
    while (frame_count != 0) begin
      w = rand_word();
      w.data_bit = 1'b0;
      send_word(FUNC_BIT, w, 1'b0, '0);
    end
    bits = frame_bits(b, !start_ok, stop_ok, 1'($urandom_range(0, 1)));
    for (int i = 0; i < 11; i++) begin
      w = rand_word();
      w.data_bit = bits[i];
      send_word(FUNC_BIT, w, 1'b0, '0);
    end
  endtask

  // Hold the sender until every awaited word is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_words.size() != 0) @(posedge clk_i);
  endtask

  // Stall the result side at random
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      pick_gap(rx_calm, stall);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Compare each taken result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("result word with nothing awaited", m_axis_tdata, 32'h0);
      end else begin
        check_word(m_axis_tdata, awaited_words.pop_front());
      end
    end
  end

  initial begin
    stim_row_t   sr;
    out_word_t   f1_word;
    logic [10:0] bits;
    logic [2:0]  f;
    logic [3:0]  r;
    logic [5:0]  idx;
    logic        start_ok;
    logic        stop_ok;
    in_word_t    w;
    int          roll;

    mismatch_count = 0;
    words_sent     = 0;
    tx_calm        = 0;
    rx_calm        = 0;
    frame_acc      = '0;
    frame_count    = '0;
    mk_break       = 1'b0;
    ed_break       = 1'b0;
    edit_q         = 1'b0;
    action_q       = ACT_NONE;
    nmi_q          = 1'b0;
    edchar_q       = '0;
    edchar_new_q   = 1'b0;
    for (int i = 0; i < MATRIX_ROWS; i++) matrix_rows[i] = '0;
    for (int i = 0; i < KEYMAP_SIZE; i++) keymap[i] = '0;
    for (int i = 0; i < EDITOR_ENTRIES; i++) editor_tab[i] = '0;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_BIT;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: reads after reset, unused kinds, table edges, then F1 and its acknowledge
    directed_rows.push_back({FUNC_READ_ROW, mk_word(0, 0, 0, 0, 0, 0, 0), 1'b1, 32'h0});
    directed_rows.push_back({FUNC_READ_ROW, mk_word(0, 15, 0, 0, 0, 0, 0), 1'b1, 32'h0});
    directed_rows.push_back({3'd7, mk_word(1, 15, 7, 63, 8'hFF, 8'hFF, 4'hF), 1'b1, 32'h0});
    directed_rows.push_back({3'd5, mk_word(1, 8, 7, 39, 8'hFF, 8'hFF, 4'hF), 1'b1, 32'h0});
    directed_rows.push_back({3'd6, mk_word(0, 0, 0, 0, 0, 0, 0), 1'b1, 32'h0});
    directed_rows.push_back({FUNC_LOAD_KEYMAP, mk_word(0, 8, 7, 0, 8'h1C, 0, 0), 1'b0, 32'h0});
    directed_rows.push_back({FUNC_LOAD_KEYMAP, mk_word(0, 0, 0, 0, 8'h15, 0, 0), 1'b0, 32'h0});
    directed_rows.push_back({FUNC_LOAD_KEYMAP, mk_word(0, 9, 3, 0, 8'h1C, 0, 0), 1'b0, 32'h0});
    directed_rows.push_back({FUNC_LOAD_EDITOR, mk_word(0, 0, 0, 39, 8'h1C, 8'hFF, 0),
                             1'b0, 32'h0});
    directed_rows.push_back({FUNC_LOAD_EDITOR, mk_word(0, 0, 0, 0, 8'hFF, 8'h01, 0),
                             1'b0, 32'h0});
    directed_rows.push_back({FUNC_LOAD_EDITOR, mk_word(0, 0, 0, 40, 8'h1C, 8'h55, 0),
                             1'b0, 32'h0});
    directed_rows.push_back({FUNC_LOAD_EDITOR, mk_word(0, 0, 0, 63, 8'h00, 8'hAA, 0),
                             1'b0, 32'h0});
    directed_rows.push_back({FUNC_ACK, mk_word(0, 0, 0, 0, 0, 0, 4'h0), 1'b0, 32'h0});
    f1_word = '0;
    f1_word.edit_active    = 1'b1;
    f1_word.action_request = ACT_F1;
    f1_word.byte_valid     = 1'b1;
    f1_word.received_byte  = SC_F1;
    bits = frame_bits(SC_F1, 1'b0, 1'b1, 1'b1);
    for (int i = 0; i < 11; i++) begin
      directed_rows.push_back({FUNC_BIT, mk_word(bits[i], 0, 0, 0, 0, 0, 0), i == 10,
                               (i == 10) ? f1_word : 32'h0});
    end
    directed_rows.push_back({FUNC_ACK, mk_word(0, 0, 0, 0, 0, 0, 4'hF), 1'b1, 32'h0});

    foreach (directed_rows[i]) begin
      sr = directed_rows[i];
      send_word(sr.f, sr.w, sr.has_typed, sr.typed_word);
    end
    drain_results();

    // Random part: mostly well-formed frames, with loads, reads, acks and noise
    while (words_sent < TOTAL_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        if ($urandom_range(0, 9) < 3) send_frame(SC_BREAK, 1'b1, 1'b1);
        send_frame(pick_scancode(), 1'b1, 1'b1);
      end else if (roll < 55) begin
        w = rand_word();
        if ($urandom_range(0, 1) == 1) w.ack_mask[ACK_EDIT] = 1'b1;
        send_word(FUNC_ACK, w, 1'b0, '0);
      end else if (roll < 65) begin
        w = rand_word();
        r = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
        w.row  = r;
        w.code = pick_pool_code();
        send_word(FUNC_LOAD_KEYMAP, w, 1'b0, '0);
      end else if (roll < 73) begin
        w = rand_word();
        idx = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63))
                                           : 6'($urandom_range(0, 39));
        w.entry_index = idx;
        w.code        = pick_pool_code();
        send_word(FUNC_LOAD_EDITOR, w, 1'b0, '0);
      end else if (roll < 83) begin
        send_word(FUNC_READ_ROW, rand_word(), 1'b0, '0);
      end else if (roll < 91) begin
        start_ok = 1'($urandom_range(0, 1));
        stop_ok  = start_ok ? 1'b0 : 1'(($urandom_range(0, 1)));
        send_frame(pick_scancode(), start_ok, stop_ok);
      end else begin
        f = 3'($urandom_range(0, 7));
        send_word(f, rand_word(), 1'b0, '0);
      end
      if ($urandom_range(0, 99) == 0) drain_results();
    end

    // Let the last results come back and check nothing extra follows
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- ps2_keyboard_to_key_matrix_top.f -----
hdl/ps2km_pkg.sv
hdl/ps2km_ram.sv
hdl/ps2km_rx.sv
hdl/ps2km_search.sv
hdl/ps2_keyboard_to_key_matrix_top.sv
hdl/ps2km_checker.sv
dv/tb_top.sv
